### rtl/usp_pkg.sv
// ----------------------------------------------------------------------------
// usp_pkg: shared definitions for the unit-weight shortest path block
// Holds field widths, op and status codes, and the job record passed from
// the front end to the back end through the job queue.
// ----------------------------------------------------------------------------
package usp_pkg;

  // Default vertex capacity of the graph.
  localparam int MAX_VERTICES = 32;

  // Fixed field widths.
  localparam int OP_W     = 2;
  localparam int VTX_IN_W = 6;
  localparam int COUNT_W  = 6;
  localparam int EFF_W    = 7;
  localparam int DIST_W   = 6;
  localparam int PATH_W   = 5;
  localparam int STATUS_W = 2;

  // Job queue depth between the front end and the back end.
  localparam int QUEUE_DEPTH = 2;

  // Vertex count after reset.
  localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd32;

  // Input op codes.
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_EDGE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOPATH = 2'd2;

  // Kinds of work the back end carries out.
  typedef enum logic [1:0] {
    JOB_CLEAR,
    JOB_EDGE,
    JOB_QUERY,
    JOB_REPLY
  } job_kind_t;

  // One classified item.
  typedef struct packed {
    job_kind_t             kind;
    logic [VTX_IN_W-1:0]   vtx_a;
    logic [VTX_IN_W-1:0]   vtx_b;
    logic [EFF_W-1:0]      count;
    logic [STATUS_W-1:0]   status;
  } job_t;

endpackage

### rtl/usp_front.sv
// ----------------------------------------------------------------------------
// usp_front: item intake and classification
// Holds the vertex count register, range-checks edge and query items, makes
// each known op a job for the back end; status-only items become reply jobs.
// ----------------------------------------------------------------------------
module usp_front #(
  parameter int MAX_VERTICES = usp_pkg::MAX_VERTICES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [usp_pkg::OP_W-1:0]      in_op,
  input  logic [usp_pkg::VTX_IN_W-1:0]  in_vertex_a,
  input  logic [usp_pkg::VTX_IN_W-1:0]  in_vertex_b,
  input  logic                          cfg_wr_en,
  input  logic [usp_pkg::COUNT_W-1:0]   cfg_wr_data,
  input  logic                          q_full,
  output logic                          push,
  output usp_pkg::job_t                 push_job
);

  localparam logic [usp_pkg::EFF_W-1:0] MAX_C = usp_pkg::EFF_W'(MAX_VERTICES);

  logic [usp_pkg::COUNT_W-1:0] count_r;
  logic [usp_pkg::EFF_W-1:0]   count_ext;
  logic [usp_pkg::EFF_W-1:0]   eff_count;
  logic                        accept;
  logic                        out_of_range;

  // Vertex count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= usp_pkg::COUNT_RESET;
    end else if (cfg_wr_en) begin
      count_r <= cfg_wr_data;
    end
  end

  // A count above the capacity acts as the capacity.
  assign count_ext = {1'b0, count_r};
  assign eff_count = (count_ext > MAX_C) ? MAX_C : count_ext;

  assign busy   = q_full;
  assign accept = start && !q_full;

  assign out_of_range = ({1'b0, in_vertex_a} >= eff_count) ||
                        ({1'b0, in_vertex_b} >= eff_count);

  // Classify the item into a job.
  always_comb begin
    push_job.kind   = usp_pkg::JOB_CLEAR;
    push_job.vtx_a  = in_vertex_a;
    push_job.vtx_b  = in_vertex_b;
    push_job.count  = eff_count;
    push_job.status = usp_pkg::ST_OK;
    push            = accept;
    unique case (in_op)
      usp_pkg::OP_CLEAR: begin
        push_job.kind = usp_pkg::JOB_CLEAR;
      end
      usp_pkg::OP_EDGE, usp_pkg::OP_QUERY: begin
        if (out_of_range) begin
          push_job.kind   = usp_pkg::JOB_REPLY;
          push_job.vtx_a  = '0;
          push_job.status = usp_pkg::ST_RANGE;
        end else if (in_op == usp_pkg::OP_EDGE) begin
          push_job.kind = usp_pkg::JOB_EDGE;
        end else if (in_vertex_a == in_vertex_b) begin
          // Source equals target: the path is that one vertex.
          push_job.kind = usp_pkg::JOB_REPLY;
        end else begin
          push_job.kind = usp_pkg::JOB_QUERY;
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

endmodule

### rtl/usp_queue.sv
// ----------------------------------------------------------------------------
// usp_queue: job queue
// A short first-in first-out buffer of jobs between the front end and the
// back end, so that intake continues while a job is being carried out.
// ----------------------------------------------------------------------------
module usp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  usp_pkg::job_t  push_job,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output usp_pkg::job_t  head
);

  localparam int PW = (usp_pkg::QUEUE_DEPTH > 1) ? $clog2(usp_pkg::QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(usp_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNTW-1:0] DEPTH_C = CNTW'(usp_pkg::QUEUE_DEPTH);
  localparam logic [PW-1:0]   LAST_C  = PW'(usp_pkg::QUEUE_DEPTH - 1);

  usp_pkg::job_t     slot_r [usp_pkg::QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     rd_ptr_r;
  logic [CNTW-1:0]   count_r;

  assign full      = (count_r == DEPTH_C);
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_C) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_C) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNTW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNTW'(1);
      end
    end
  end

endmodule

### rtl/usp_back.sv
// ----------------------------------------------------------------------------
// usp_back: graph store and search engine
// Holds the adjacency matrix, carries out clear, edge, query and reply jobs,
// runs the vertex scan of each selection round and sends the path out.
// ----------------------------------------------------------------------------
module usp_back #(
  parameter int MAX_VERTICES = usp_pkg::MAX_VERTICES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          job_valid,
  input  usp_pkg::job_t                 job,
  output logic                          pop,
  output logic                          out_strobe,
  output logic [usp_pkg::PATH_W-1:0]    out_path_vertex,
  output logic [usp_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_last
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int DW = usp_pkg::DIST_W;

  typedef enum logic [3:0] {
    S_IDLE, S_E_RDA, S_E_WRA, S_E_RDB, S_E_WRB,
    S_ROW_RD, S_ROW_CAP, S_SCAN, S_DECIDE,
    S_BT_PUSH, S_BT_WAIT, S_EM_RD, S_EM_SEND
  } state_t;

  state_t                  state_r;
  logic [VW-1:0]           a_r, b_r, cur_r, p_i_r, best_r, v_r;
  logic [CW-1:0]           n_r, scan_r, len_r;
  logic [DW-1:0]           curd_r, bestd_r;
  logic [MAX_VERTICES-1:0] row_r, sel_r, reach_r, row_valid_r;
  logic                    p_vld_r, found_r;
  logic                    out_strobe_r, out_last_r;
  logic [usp_pkg::PATH_W-1:0]   out_vertex_r;
  logic [usp_pkg::STATUS_W-1:0] out_status_r;

  // Memories and their registered read data.
  logic [MAX_VERTICES-1:0] adj_mem_r   [MAX_VERTICES];
  logic [DW-1:0]           dist_mem_r  [MAX_VERTICES];
  logic [VW-1:0]           pred_mem_r  [MAX_VERTICES];
  logic [VW-1:0]           stack_mem_r [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adj_rd_r;
  logic                    adj_vld_rd_r;
  logic [DW-1:0]           dist_rd_r;
  logic [VW-1:0]           pred_rd_r, stack_rd_r;

  logic [VW-1:0]           adj_ra, adj_wa, adj_other;
  logic                    adj_we;
  logic [MAX_VERTICES-1:0] adj_wd;
  logic                    dist_we;
  logic [VW-1:0]           dist_wa, pred_wd;
  logic [DW-1:0]           dist_wd;
  logic [CW-1:0]           len_dec, len_inc;
  logic [VW-1:0]           job_a, job_b;
  logic [DW-1:0]           nd, di;
  logic                    in_scan, unsel, adj_bit, rch, upd, cand, better;

  assign job_a   = job.vtx_a[VW-1:0];
  assign job_b   = job.vtx_b[VW-1:0];
  assign pop     = (state_r == S_IDLE) && job_valid;
  assign len_dec = len_r - CW'(1);
  assign len_inc = len_r + CW'(1);

  // Adjacency port: read-modify-write of one row per edge endpoint.
  always_comb begin
    unique case (state_r)
      S_E_RDA: adj_ra = a_r;
      S_E_RDB: adj_ra = b_r;
      default: adj_ra = cur_r;
    endcase
  end
  assign adj_we    = (state_r == S_E_WRA) || (state_r == S_E_WRB);
  assign adj_wa    = (state_r == S_E_WRA) ? a_r : b_r;
  assign adj_other = (state_r == S_E_WRA) ? b_r : a_r;
  assign adj_wd    = (adj_vld_rd_r ? adj_rd_r : '0) | (MAX_VERTICES'(1) << adj_other);

  // Relaxation and selection for the vertex in the process stage.
  assign in_scan = (state_r == S_SCAN) && p_vld_r;
  assign nd      = curd_r + DW'(1);
  assign unsel   = !sel_r[p_i_r];
  assign adj_bit = row_r[p_i_r];
  assign rch     = reach_r[p_i_r];
  assign upd     = in_scan && unsel && adj_bit && (!rch || (nd < dist_rd_r));
  assign di      = upd ? nd : dist_rd_r;
  assign cand    = in_scan && unsel && (rch || upd);
  assign better  = cand && (!found_r || (di < bestd_r));

  // Distance and predecessor write port: query start or relaxation.
  always_comb begin
    if (pop && (job.kind == usp_pkg::JOB_QUERY)) begin
      dist_we = 1'b1;
      dist_wa = job_a;
      dist_wd = '0;
      pred_wd = job_a;
    end else begin
      dist_we = upd;
      dist_wa = p_i_r;
      dist_wd = nd;
      pred_wd = cur_r;
    end
  end

  // Memory arrays.
  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem_r[adj_wa] <= adj_wd;
    end
    adj_rd_r     <= adj_mem_r[adj_ra];
    adj_vld_rd_r <= row_valid_r[adj_ra];
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem_r[dist_wa] <= dist_wd;
      pred_mem_r[dist_wa] <= pred_wd;
    end
    dist_rd_r <= dist_mem_r[scan_r[VW-1:0]];
    pred_rd_r <= pred_mem_r[v_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_BT_PUSH) begin
      stack_mem_r[len_r[VW-1:0]] <= v_r;
    end
    stack_rd_r <= stack_mem_r[len_dec[VW-1:0]];
  end

  // Sequencer with registered result outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      row_valid_r  <= '0;
      out_strobe_r <= 1'b0;
      p_vld_r      <= 1'b0;
      found_r      <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            unique case (job.kind)
              usp_pkg::JOB_CLEAR: begin
                row_valid_r <= '0;
              end
              usp_pkg::JOB_EDGE: begin
                a_r     <= job_a;
                b_r     <= job_b;
                state_r <= S_E_RDA;
              end
              usp_pkg::JOB_REPLY: begin
                out_strobe_r <= 1'b1;
                out_vertex_r <= usp_pkg::PATH_W'(job.vtx_a);
                out_status_r <= job.status;
                out_last_r   <= 1'b1;
              end
              usp_pkg::JOB_QUERY: begin
                a_r     <= job_a;
                b_r     <= job_b;
                n_r     <= job.count[CW-1:0];
                cur_r   <= job_a;
                curd_r  <= '0;
                sel_r   <= MAX_VERTICES'(1) << job_a;
                reach_r <= MAX_VERTICES'(1) << job_a;
                state_r <= S_ROW_RD;
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_E_RDA: state_r <= S_E_WRA;
        S_E_WRA: begin
          row_valid_r[adj_wa] <= 1'b1;
          state_r             <= S_E_RDB;
        end
        S_E_RDB: state_r <= S_E_WRB;
        S_E_WRB: begin
          row_valid_r[adj_wa] <= 1'b1;
          state_r             <= S_IDLE;
        end
        S_ROW_RD: state_r <= S_ROW_CAP;
        S_ROW_CAP: begin
          row_r   <= adj_vld_rd_r ? adj_rd_r : '0;
          scan_r  <= '0;
          p_vld_r <= 1'b0;
          found_r <= 1'b0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (upd) begin
            reach_r[p_i_r] <= 1'b1;
          end
          if (better) begin
            found_r <= 1'b1;
            best_r  <= p_i_r;
            bestd_r <= di;
          end
          if (scan_r < n_r) begin
            p_vld_r <= 1'b1;
            p_i_r   <= scan_r[VW-1:0];
            scan_r  <= scan_r + CW'(1);
          end else begin
            p_vld_r <= 1'b0;
            if (!p_vld_r) begin
              state_r <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          if (!found_r) begin
            // Nothing left to select: the target cannot be reached.
            out_strobe_r <= 1'b1;
            out_vertex_r <= '0;
            out_status_r <= usp_pkg::ST_NOPATH;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end else begin
            sel_r[best_r] <= 1'b1;
            cur_r         <= best_r;
            curd_r        <= bestd_r;
            if (best_r == b_r) begin
              v_r     <= b_r;
              len_r   <= '0;
              state_r <= S_BT_PUSH;
            end else begin
              state_r <= S_ROW_RD;
            end
          end
        end
        S_BT_PUSH: begin
          len_r <= len_inc;
          if ((v_r == a_r) || (len_inc == n_r)) begin
            state_r <= S_EM_RD;
          end else begin
            state_r <= S_BT_WAIT;
          end
        end
        S_BT_WAIT: begin
          v_r     <= pred_rd_r;
          state_r <= S_BT_PUSH;
        end
        S_EM_RD: begin
          len_r   <= len_dec;
          state_r <= S_EM_SEND;
        end
        S_EM_SEND: begin
          out_strobe_r <= 1'b1;
          out_vertex_r <= usp_pkg::PATH_W'(stack_rd_r);
          out_status_r <= usp_pkg::ST_OK;
          out_last_r   <= (len_r == '0);
          state_r      <= (len_r == '0) ? S_IDLE : S_EM_RD;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_path_vertex = out_vertex_r;
  assign out_status      = out_status_r;
  assign out_last        = out_last_r;

  // The source stays selected throughout a scan.
  a_scan_sel: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (sel_r != '0))
    else $error("selected mask empty during scan");

  // A chosen vertex was not selected before.
  a_best_new: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DECIDE) && found_r) |-> !sel_r[best_r])
    else $error("best vertex already selected");

  // Error results always close their item.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && (out_status_r != usp_pkg::ST_OK)) |-> out_last_r)
    else $error("error result without last");

  // The path stack never overflows the vertex count.
  a_stack: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BT_PUSH) |-> (len_r < n_r))
    else $error("path stack overflow");

endmodule

### rtl/unit_weight_shortest_path_top.sv
// ----------------------------------------------------------------------------
// unit_weight_shortest_path_top: unit-weight shortest path engine
// Keeps an undirected graph as an adjacency bit matrix and answers shortest
// path queries, emitting the path one vertex per result.
// ----------------------------------------------------------------------------
// Usage:
// An item is taken at a clock edge with start high and busy low. Ops are
// clear graph, add edge and path query. busy rises only when the two-entry
// job queue is full. Each result appears for one cycle with out_strobe high;
// out_last marks the final result of an item. The receiver cannot stall.
// Processing:
// A clear or status-only item is handled in the idle state; an edge does a
// read-modify-write of each endpoint row. A query runs one selection round
// per selected vertex; each round reads one adjacency row and scans the n
// vertices through the distance memory. The path is then walked back through
// the predecessor memory onto a stack and sent out one vertex per result.
// The engine takes the next job from the queue only once it is idle again.
// Reset clears the graph through row valid bits, empties the queue and sets
// the vertex count to 32. cfg_wr_en writes the count; the user must assert it
// only while the block is idle, since the block itself does not enforce this.
// ----------------------------------------------------------------------------
module unit_weight_shortest_path_top #(
  parameter int MAX_VERTICES = usp_pkg::MAX_VERTICES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [usp_pkg::OP_W-1:0]      in_op,
  input  logic [usp_pkg::VTX_IN_W-1:0]  in_vertex_a,
  input  logic [usp_pkg::VTX_IN_W-1:0]  in_vertex_b,
  input  logic                          cfg_wr_en,
  input  logic [usp_pkg::COUNT_W-1:0]   cfg_wr_data,
  output logic                          out_strobe,
  output logic [usp_pkg::PATH_W-1:0]    out_path_vertex,
  output logic [usp_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_last
);

  logic          q_full, q_push, q_pop, q_not_empty;
  usp_pkg::job_t q_in, q_head;

  // Intake and classification.
  usp_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_op       (in_op),
    .in_vertex_a (in_vertex_a),
    .in_vertex_b (in_vertex_b),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .push        (q_push),
    .push_job    (q_in)
  );

  // Job queue.
  usp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Graph store and search engine.
  usp_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (q_not_empty),
    .job             (q_head),
    .pop             (q_pop),
    .out_strobe      (out_strobe),
    .out_path_vertex (out_path_vertex),
    .out_status      (out_status),
    .out_last        (out_last)
  );

endmodule
